### hw/rtl/sha1md_pkg.sv
package sha1md_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAD,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN_LO
  } pad_step_t;

  typedef enum logic [2:0] {
    WSEL_INPUT,
    WSEL_FINAL,
    WSEL_MARK,
    WSEL_ZERO,
    WSEL_LEN_HI,
    WSEL_LEN_LO
  } wsel_t;

  typedef enum logic [1:0] {
    LEN_ADD_NONE,
    LEN_ADD_FULL,
    LEN_ADD_FINAL
  } len_add_t;

  typedef struct packed {
    logic      push;
    wsel_t     wsel;
    len_add_t  len_add;
    logic      start;
    logic      round;
    logic [1:0] phase;
    logic      finish;
    logic      clear;
    logic [2:0] emit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_final;
    logic final_full;
  } dp_status_t;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [31:0] IV [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [31:0] MARK_WORD   = 32'h8000_0000;
  localparam logic [3:0]  LAST_SLOT   = 4'd15;
  localparam logic [3:0]  LEN_HI_SLOT = 4'd14;
  localparam logic [6:0]  LAST_ROUND  = 7'd79;
  localparam logic [6:0]  PHASE1_ROUND = 7'd20;
  localparam logic [6:0]  PHASE2_ROUND = 7'd40;
  localparam logic [6:0]  PHASE3_ROUND = 7'd60;
  localparam logic [2:0]  LAST_DIGEST = 3'd4;
  localparam logic [2:0]  FULL_BYTES  = 3'd4;

  function automatic logic [31:0] round_fn(input logic [1:0] phase,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
    logic [31:0] r;
    case (phase)
      2'd0:    r = (b & c) | (~b & d);
      2'd2:    r = (b & c) | (b & d) | (c & d);
      default: r = b ^ c ^ d;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [1:0] phase);
    logic [31:0] r;
    case (phase)
      2'd0:    r = K0;
      2'd1:    r = K1;
      2'd2:    r = K2;
      default: r = K3;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/sha1_message_digest.sv
// message words: one transaction per cycle while a block fills; the 16th word of a block
//   holds msg_stall high through the 80 rounds and the chaining add
// final word: padding words and one or two compressions, then the five digest
//   words H0..H4 follow, one transaction per cycle when dig_stall is low
// reset (rst, synchronous, active high): controller idle, chaining value to the initial
//   vector, bit length to zero; the block buffer is not cleared
module sha1_message_digest #(
  parameter int LENGTH_COUNTER_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // message channel
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [31:0] message_word,
  input  logic [2:0]  bytes_valid,
  input  logic        final_word,
  // digest channel
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  // commands from the sequencer, input classification back from the datapath
  sha1md_pkg::dp_cmd_t    cmd;
  sha1md_pkg::dp_status_t status;

  // sequencer: block fill count, padding steps, round counter, digest index
  sha1md_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .dig_valid  (dig_valid),
    .dig_stall  (dig_stall),
    .status     (status),
    .cmd        (cmd),
    .word_index (word_index),
    .last_word  (last_word)
  );

  // datapath: schedule window, round registers, chaining value, bit length
  sha1md_datapath #(
    .LENGTH_COUNTER_BITS (LENGTH_COUNTER_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .message_word (message_word),
    .bytes_valid  (bytes_valid),
    .final_word   (final_word),
    .cmd          (cmd),
    .status       (status),
    .digest_word  (digest_word)
  );

endmodule

### hw/rtl/sha1md_ctrl.sv
module sha1md_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  output logic                  dig_valid,
  input  logic                  dig_stall,
  input  sha1md_pkg::dp_status_t status,
  output sha1md_pkg::dp_cmd_t   cmd,
  output logic [2:0]            word_index,
  output logic                  last_word
);

  sha1md_pkg::state_t    state, state_next;
  sha1md_pkg::state_t    resume, resume_next;
  sha1md_pkg::state_t    target;
  sha1md_pkg::pad_step_t pad_step, pad_step_next;
  logic [3:0] fill, fill_next;
  logic [6:0] round_count, round_count_next;
  logic [2:0] emit_idx, emit_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sha1md_pkg::ST_LOAD;
      resume      <= sha1md_pkg::ST_LOAD;
      pad_step    <= sha1md_pkg::PAD_ZERO;
      fill        <= '0;
      round_count <= '0;
      emit_idx    <= '0;
    end else begin
      state       <= state_next;
      resume      <= resume_next;
      pad_step    <= pad_step_next;
      fill        <= fill_next;
      round_count <= round_count_next;
      emit_idx    <= emit_idx_next;
    end
  end

  always_comb begin
    state_next       = state;
    resume_next      = resume;
    pad_step_next    = pad_step;
    fill_next        = fill;
    round_count_next = round_count;
    emit_idx_next    = emit_idx;
    target           = state;
    msg_stall        = 1'b1;
    dig_valid        = 1'b0;
    cmd.push         = 1'b0;
    cmd.wsel         = sha1md_pkg::WSEL_ZERO;
    cmd.len_add      = sha1md_pkg::LEN_ADD_NONE;
    cmd.start        = 1'b0;
    cmd.round        = 1'b0;
    cmd.phase        = 2'd0;
    cmd.finish       = 1'b0;
    cmd.clear        = 1'b0;
    cmd.emit_idx     = emit_idx;

    case (state)
      sha1md_pkg::ST_LOAD: begin
        msg_stall = 1'b0;
        if (msg_valid) begin
          cmd.push  = 1'b1;
          fill_next = fill + 4'd1;
          if (!status.is_final) begin
            cmd.wsel    = sha1md_pkg::WSEL_INPUT;
            cmd.len_add = sha1md_pkg::LEN_ADD_FULL;
            target      = sha1md_pkg::ST_LOAD;
          end else begin
            cmd.len_add = sha1md_pkg::LEN_ADD_FINAL;
            target      = sha1md_pkg::ST_PAD;
            if (status.final_full) begin
              cmd.wsel      = sha1md_pkg::WSEL_INPUT;
              pad_step_next = sha1md_pkg::PAD_MARK;
            end else begin
              cmd.wsel      = sha1md_pkg::WSEL_FINAL;
              pad_step_next = sha1md_pkg::PAD_ZERO;
            end
          end
          if (fill == sha1md_pkg::LAST_SLOT) begin
            cmd.start   = 1'b1;
            resume_next = target;
            state_next  = sha1md_pkg::ST_ROUND;
          end else begin
            state_next = target;
          end
        end
      end

      sha1md_pkg::ST_PAD: begin
        cmd.push  = 1'b1;
        fill_next = fill + 4'd1;
        target    = sha1md_pkg::ST_PAD;
        case (pad_step)
          sha1md_pkg::PAD_MARK: begin
            cmd.wsel      = sha1md_pkg::WSEL_MARK;
            pad_step_next = sha1md_pkg::PAD_ZERO;
          end
          sha1md_pkg::PAD_LEN_LO: begin
            cmd.wsel = sha1md_pkg::WSEL_LEN_LO;
            target   = sha1md_pkg::ST_EMIT;
          end
          default: begin
            if (fill == sha1md_pkg::LEN_HI_SLOT) begin
              cmd.wsel      = sha1md_pkg::WSEL_LEN_HI;
              pad_step_next = sha1md_pkg::PAD_LEN_LO;
            end else begin
              cmd.wsel = sha1md_pkg::WSEL_ZERO;
            end
          end
        endcase
        if (fill == sha1md_pkg::LAST_SLOT) begin
          cmd.start   = 1'b1;
          resume_next = target;
          state_next  = sha1md_pkg::ST_ROUND;
        end else begin
          state_next = target;
        end
      end

      sha1md_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (round_count < sha1md_pkg::PHASE1_ROUND) begin
          cmd.phase = 2'd0;
        end else if (round_count < sha1md_pkg::PHASE2_ROUND) begin
          cmd.phase = 2'd1;
        end else if (round_count < sha1md_pkg::PHASE3_ROUND) begin
          cmd.phase = 2'd2;
        end else begin
          cmd.phase = 2'd3;
        end
        round_count_next = round_count + 7'd1;
        if (round_count == sha1md_pkg::LAST_ROUND) begin
          round_count_next = '0;
          state_next       = sha1md_pkg::ST_FINISH;
        end
      end

      sha1md_pkg::ST_FINISH: begin
        cmd.finish    = 1'b1;
        emit_idx_next = '0;
        state_next    = resume;
      end

      sha1md_pkg::ST_EMIT: begin
        dig_valid = 1'b1;
        if (!dig_stall) begin
          if (emit_idx == sha1md_pkg::LAST_DIGEST) begin
            emit_idx_next = '0;
            cmd.clear     = 1'b1;
            state_next    = sha1md_pkg::ST_LOAD;
          end else begin
            emit_idx_next = emit_idx + 3'd1;
          end
        end
      end

      default: begin
        state_next = sha1md_pkg::ST_LOAD;
      end
    endcase
  end

  assign word_index = emit_idx;
  assign last_word  = (emit_idx == sha1md_pkg::LAST_DIGEST);

endmodule

### hw/rtl/sha1md_datapath.sv
module sha1md_datapath #(
  parameter int LENGTH_COUNTER_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            message_word,
  input  logic [2:0]             bytes_valid,
  input  logic                   final_word,
  input  sha1md_pkg::dp_cmd_t    cmd,
  output sha1md_pkg::dp_status_t status,
  output logic [31:0]            digest_word
);

  logic [31:0] chain [5];
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [LENGTH_COUNTER_BITS-1:0] len;
  logic [63:0] len64;
  logic [2:0]  nbytes;
  logic [5:0]  final_bits;
  logic [31:0] final_masked;
  logic [31:0] push_word;
  logic [31:0] w_new;
  logic [31:0] t;

  // saturate the byte count, pad byte lands right after the last valid byte
  assign nbytes     = (bytes_valid > sha1md_pkg::FULL_BYTES) ? sha1md_pkg::FULL_BYTES
                                                               : bytes_valid;
  assign final_bits = {nbytes, 3'b000};
  assign len64      = 64'(len);

  always_comb begin
    case (nbytes[1:0])
      2'd1:    final_masked = {message_word[31:24], 24'h80_0000};
      2'd2:    final_masked = {message_word[31:16], 16'h8000};
      2'd3:    final_masked = {message_word[31:8], 8'h80};
      default: final_masked = sha1md_pkg::MARK_WORD;
    endcase
  end

  always_comb begin
    case (cmd.wsel)
      sha1md_pkg::WSEL_INPUT:  push_word = message_word;
      sha1md_pkg::WSEL_FINAL:  push_word = final_masked;
      sha1md_pkg::WSEL_MARK:   push_word = sha1md_pkg::MARK_WORD;
      sha1md_pkg::WSEL_LEN_HI: push_word = len64[63:32];
      sha1md_pkg::WSEL_LEN_LO: push_word = len64[31:0];
      default:                 push_word = '0;
    endcase
  end

  assign status.is_final   = final_word;
  assign status.final_full = (nbytes == sha1md_pkg::FULL_BYTES);

  // schedule window: w[0] is the word of the current round
  assign w_new = {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
                  w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};

  assign t = {a[26:0], a[31:27]} + sha1md_pkg::round_fn(cmd.phase, b, c, d) + e + w[0]
             + sha1md_pkg::round_k(cmd.phase);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= push_word;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (cmd.round) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= sha1md_pkg::IV[i];
      end
    end else if (cmd.finish) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      len <= '0;
    end else begin
      case (cmd.len_add)
        sha1md_pkg::LEN_ADD_FULL:  len <= len + LENGTH_COUNTER_BITS'(32);
        sha1md_pkg::LEN_ADD_FINAL: len <= len + LENGTH_COUNTER_BITS'(final_bits);
        default:                   len <= len;
      endcase
    end
  end

  always_comb begin
    case (cmd.emit_idx)
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      3'd4:    digest_word = chain[4];
      default: digest_word = chain[0];
    endcase
  end

endmodule

### hw/rtl/sha1md_checker.sv
module sha1md_checker (
  input logic        clk,
  input logic        rst,
  input logic        msg_stall,
  input logic        dig_valid,
  input logic        dig_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // a stalled digest transaction holds
  a_dig_hold: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_stall) |=> (dig_valid && $stable(digest_word)
                                  && $stable(word_index)))
    else $error("digest transaction changed while stalled");

  // no message word is taken while digest words are pending
  a_no_input_on_emit: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> msg_stall)
    else $error("message accepted during digest output");

  // digest words come back to back in index order
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_stall && !last_word) |=>
      (dig_valid && word_index == 3'($past(word_index) + 3'd1)))
    else $error("digest word index out of sequence");

  // last flag marks exactly the fifth word
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (last_word == (word_index == 3'd4)))
    else $error("last_word does not match word_index");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !dig_valid)
    else $error("digest valid right after reset");

endmodule

bind sha1_message_digest sha1md_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .msg_stall   (msg_stall),
  .dig_valid   (dig_valid),
  .dig_stall   (dig_stall),
  .digest_word (digest_word),
  .word_index  (word_index),
  .last_word   (last_word)
);

### dv/sha1_message_digest_tb.sv
`timescale 1ns / 1ps

// sha-1 digest unit: message words go in on the msg channel, five digest words come out
// on the dig channel after each word flagged final; every digest word is checked against
// a local sha-1 engine tracking chaining value, block buffer and bit length, or a typed digest
module sha1_message_digest_tb;

  localparam int RANDOM_ITEMS = 250;
  // slowest run: every word ends a message, each behind the longest gap, with padding,
  // two compressions and five digest words each waiting out the longest stall, plus one
  // long hold-off; the limit is taken well over that
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 40;
  localparam int DIR_ROWS     = 23;

  // one digest word as it appears on the output channel
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last_flag;
  } digest_beat_t;

  // one row of the directed table; when known is set the typed digest is expected
  typedef struct packed {
    logic [31:0]  word;
    logic [2:0]   nbytes;
    logic         ends_msg;
    logic         known;
    logic [159:0] digest;
  } stim_row_t;

  localparam logic [159:0] SHA1_EMPTY =
    160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam logic [159:0] SHA1_ABC =
    160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

  localparam logic [31:0] SHA1_IV [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{32'h0000_0000, 3'd0, 1'b1, 1'b1, SHA1_EMPTY},  // empty message
    '{32'h6162_6300, 3'd3, 1'b1, 1'b1, SHA1_ABC},    // "abc"
    '{32'h6162_63A5, 3'd3, 1'b1, 1'b1, SHA1_ABC},    // junk past the byte count is dropped
    '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, '0},          // byte count ignored on a non-final word
    '{32'h0000_0000, 3'd7, 1'b1, 1'b0, '0},          // byte count above four saturates
    '{32'hFFFF_FFFF, 3'd1, 1'b1, 1'b0, '0},          // single byte
    '{32'h80FF_00FF, 3'd2, 1'b1, 1'b0, '0},          // two bytes
    '{32'h1234_5678, 3'd4, 1'b1, 1'b0, '0},          // full final word, mark in next word
    // fourteen full words, then a zero-byte final: the mark lands in slot 14 and
    // the length spills into an extra block
    '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 3'd5, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 3'd6, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 3'd7, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 3'd1, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 3'd2, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 3'd3, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 3'd4, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 3'd4, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 3'd4, 1'b0, 1'b0, '0},
    '{32'hDEAD_BEEF, 3'd0, 1'b1, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_stall;
  logic [31:0] message_word = 32'h0;
  logic [2:0]  bytes_valid = 3'd0;
  logic        final_word = 1'b0;
  logic        dig_valid;
  logic        dig_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // shared traffic controls
  bit calm = 1'b0;      // no random idling on either side while set
  bit hold_go = 1'b0;   // kicks off the long receiver hold-off
  bit hold_off = 1'b0;
  int errors = 0;

  // local sha-1 engine state
  logic [31:0]  chain_h [5];
  logic [31:0]  block_w [16];
  int unsigned  block_fill;
  logic [63:0]  bit_count;
  digest_beat_t digest_due [$];

  always #4 clk = ~clk;

  sha1_message_digest dut (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .message_word (message_word),
    .bytes_valid  (bytes_valid),
    .final_word   (final_word),
    .dig_valid    (dig_valid),
    .dig_stall    (dig_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // back to the initial vector with an empty length count
  function automatic void sha1_restart();
    int i;
    for (i = 0; i < 5; i++) chain_h[i] = SHA1_IV[i];
    block_fill = 0;
    bit_count  = 64'd0;
  endfunction

  // 80 rounds over the buffered block, folded into the chaining value
  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++) w[r] = block_w[r];
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16)
        w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A82_7999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9_EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1B_BCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62_C1D6;
      end
      t = rotl(a, 5) + f + e + w[r % 16] + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void absorb_word(input logic [31:0] w);
    block_w[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      sha1_compress();
      block_fill = 0;
    end
  endfunction

  // takes one message word; returns 1 with the digest when the word ends the message
  function automatic bit sha1_take(input logic [31:0] word, input logic [2:0] nbytes,
                                   input logic ends_msg, output logic [159:0] digest);
    int unsigned n;
    logic [31:0] keep;
    digest = '0;
    if (!ends_msg) begin
      bit_count += 64'd32;
      absorb_word(word);
      return 1'b0;
    end
    n = (nbytes > 3'd4) ? 4 : nbytes;
    bit_count += 64'(n * 8);
    if (n == 4) begin
      absorb_word(word);
      absorb_word(32'h8000_0000);
    end else begin
      // keep the leading bytes, mark right behind them
      keep = ~(32'hFFFF_FFFF >> (8 * n));
      absorb_word((word & keep) | (32'h80 << (24 - 8 * n)));
    end
    while (block_fill != 14) absorb_word(32'h0);
    absorb_word(bit_count[63:32]);
    absorb_word(bit_count[31:0]);
    digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
    sha1_restart();
    return 1'b1;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] random_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // one message transaction; called at a rising edge, returns at the accepting edge
  task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes,
                           input logic ends_msg, input logic known,
                           input logic [159:0] known_digest);
    int gap;
    int i;
    bit took;
    bit done;
    logic [159:0] digest;
    gap = calm ? 0 : gap_length();
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid    <= 1'b1;
    message_word <= word;
    bytes_valid  <= nbytes;
    final_word   <= ends_msg;
    // stall is settled mid-cycle; low there means the next edge takes the word
    do begin
      @(negedge clk);
      took = !msg_stall;
      @(posedge clk);
    end while (!took);
    done = sha1_take(word, nbytes, ends_msg, digest);
    if (done) begin
      if (known) digest = known_digest;
      for (i = 0; i < 5; i++)
        digest_due.push_back(digest_beat_t'{digest[159 - 32 * i -: 32], 3'(i), i == 4});
    end
  endtask

  // digest receiver: random stalls, forced high during the long hold-off
  initial begin : digest_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        dig_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        dig_stall <= 1'b1;
      end else begin
        stall_left = calm ? 0 : gap_length();
        dig_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // long hold-off: the receiver blocks while the sender keeps offering words,
  // so the unit fills up and stalls its input
  initial begin : long_hold
    int held;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off <= 1'b0;
  end

  // digest checker: a transaction happens at the edge after a negedge with valid and no stall
  always @(negedge clk) begin
    digest_beat_t want;
    if (!rst && dig_valid && !dig_stall) begin
      if (digest_due.size() == 0) begin
        $display("%0t: digest word with nothing expected: index %0d data %h last %b",
                 $time, word_index, digest_word, last_word);
        errors++;
      end else begin
        want = digest_due.pop_front();
        if (digest_word !== want.word) begin
          $display("%0t: digest_word expected %h, got %h", $time, want.word, digest_word);
          errors++;
        end
        if (word_index !== want.idx) begin
          $display("%0t: word_index expected %0d, got %0d", $time, want.idx, word_index);
          errors++;
        end
        if (last_word !== want.last_flag) begin
          $display("%0t: last_word expected %b, got %b", $time, want.last_flag, last_word);
          errors++;
        end
      end
    end
  end

  // cycle budget
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout, %0d digest words still expected", $time, digest_due.size());
    $display("** sha1_message_digest: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int row;
    int sel;
    int nwords;
    int sent;
    int msgs;
    sha1_restart();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (row = 0; row < DIR_ROWS; row++)
      send_word(DIRECTED[row].word, DIRECTED[row].nbytes, DIRECTED[row].ends_msg,
                DIRECTED[row].known, DIRECTED[row].digest);

    // random messages: mostly short, many sized around the block boundary
    // where the padding needs an extra block, a few spanning several blocks
    sent = 0;
    msgs = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if (msgs == 4) hold_go = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 60) nwords = $urandom_range(0, 17);
      else if (sel < 85) nwords = $urandom_range(12, 15) + 16 * $urandom_range(0, 1);
      else nwords = $urandom_range(18, 40);
      repeat (nwords) begin
        send_word(random_word(), 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
        sent++;
      end
      send_word(random_word(), 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
      sent++;
      msgs++;
    end
    msg_valid <= 1'b0;
    calm = 1'b0;

    // drain the digest words still in flight
    while (digest_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("** sha1_message_digest: PASSED **");
    else
      $display("** sha1_message_digest: FAILED **");
    $finish;
  end

endmodule
